>>> sv/masked_run_length_encoder_assert.svh
// Assertion macros shared by the assertions of the masked run-length encoder checker.
`ifndef MASKED_RUN_LENGTH_ENCODER_ASSERT_SVH
`define MASKED_RUN_LENGTH_ENCODER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define MRLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("masked run-length encoder assertion failed");

// Antecedent implies consequent in the next cycle.
`define MRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("masked run-length encoder assertion failed");

`endif

>>> sv/mrle_pkg.sv
// Shared types, constants and helper functions of the masked run-length encoder.
package mrle_pkg;

	localparam int unsigned TILE_W = 8;
	localparam int unsigned LEN_W  = 8;
	localparam int unsigned CAP_W  = 10;
	localparam int unsigned APB_DW = 32;
	localparam int unsigned PADDR_W = 3;

	localparam logic [LEN_W-1:0] MAX_RUN   = 8'd255;
	localparam logic [CAP_W-1:0] CAP_RESET = 10'd512;

	// Register index, taken from the word address bits of paddr.
	localparam logic [PADDR_W-3:0] REG_CAPACITY = 1'b0;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = 2;
	localparam int unsigned QUEUE_CW    = QUEUE_AW + 1;

	// One queue entry: an optional closed run, and for a room's last tile the flushed run.
	typedef struct packed {
		logic              has_a;
		logic [LEN_W-1:0]  len_a;
		logic [TILE_W-1:0] val_a;
		logic [LEN_W-1:0]  len_b;
		logic [TILE_W-1:0] val_b;
		logic              last;
	} cmd_t;

	function automatic logic is_sprite_code(input logic [TILE_W-1:0] code);
		return code inside {8'd18, 8'd22, 8'd23, 8'd26, 8'd28, 8'd64, 8'd8,
			8'd20, 8'd11, 8'd12, 8'd86, 8'd96, 8'd118};
	endfunction

	function automatic logic [TILE_W-1:0] mask_tile(input logic [TILE_W-1:0] code);
		return is_sprite_code(code) ? '0 : code;
	endfunction

endpackage

>>> sv/masked_run_length_encoder.sv
// The command queue and the output register lie between a run's closing tile beat and
// its result beat; a room's last tile may give a second beat from the flush step.
// Throughput: one tile per cycle unless the queue is full; the back end takes a pair
// and a flush step on a last tile that closes a run; the four-entry queue absorbs that.
// Reset clears the open run, the queue, the byte count and overflow flag, and sets
// the capacity register to 512.
module masked_run_length_encoder (
	input  logic                               clk,
	input  logic                               arst_n,
	// Tile input channel.
	input  logic                               tile_valid,
	output logic                               tile_stall,
	input  logic [mrle_pkg::TILE_W-1:0]        tile_value,
	input  logic                               last_tile,
	// Run result channel.
	output logic                               run_valid,
	input  logic                               run_stall,
	output logic [mrle_pkg::LEN_W-1:0]         run_length,
	output logic [mrle_pkg::TILE_W-1:0]        run_value,
	output logic                               room_done,
	output logic                               overflow,
	// Configuration port.
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mrle_pkg::PADDR_W-1:0]       paddr,
	input  logic [mrle_pkg::APB_DW-1:0]        pwdata,
	output logic [mrle_pkg::APB_DW-1:0]        prdata,
	output logic                               pready
);
	import mrle_pkg::*;

	logic [CAP_W-1:0]   cap_q;
	logic [PADDR_W-3:0] reg_index;
	logic               cfg_write;

	logic tile_fire;
	logic push;
	cmd_t push_data;
	logic pop;
	cmd_t head;
	logic q_empty;
	logic q_full;

	// The register file holds only the capacity; pready is tied high so every
	// access completes in its access cycle.
	assign pready    = 1'b1;
	assign reg_index = paddr[PADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (reg_index == REG_CAPACITY) ? {{(APB_DW - CAP_W){1'b0}}, cap_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_write && (reg_index == REG_CAPACITY)) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// The front end keeps taking tiles as long as the queue has a free entry,
	// independent of whether the result beat is being stalled downstream.
	assign tile_stall = q_full;
	assign tile_fire  = tile_valid && !tile_stall;

	mrle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tile_fire  (tile_fire),
		.tile_value (tile_value),
		.last_tile  (last_tile),
		.push       (push),
		.push_data  (push_data)
	);

	mrle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	// The back end owns the per-room byte count and overflow flag and the
	// output register that parts it from the downstream side.
	mrle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.capacity   (cap_q),
		.head       (head),
		.empty      (q_empty),
		.pop        (pop),
		.run_stall  (run_stall),
		.run_valid  (run_valid),
		.run_length (run_length),
		.run_value  (run_value),
		.room_done  (room_done),
		.overflow   (overflow)
	);

endmodule

>>> sv/mrle_front.sv
// Front end: masks entity tiles and merges equal tiles into runs.
module mrle_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        tile_fire,
	input  logic [mrle_pkg::TILE_W-1:0] tile_value,
	input  logic                        last_tile,
	output logic                        push,
	output mrle_pkg::cmd_t              push_data
);
	import mrle_pkg::*;

	logic [TILE_W-1:0] cur_val_q;
	logic [LEN_W-1:0]  cur_cnt_q;

	logic [TILE_W-1:0] v;
	logic              opening;
	logic              extend;
	logic              close;
	logic [TILE_W-1:0] next_val;
	logic [LEN_W-1:0]  next_cnt;

	always_comb begin
		v        = mask_tile(tile_value);
		opening  = (cur_cnt_q == '0);
		extend   = !opening && (v == cur_val_q) && (cur_cnt_q < MAX_RUN);
		close    = !opening && !extend;
		next_val = extend ? cur_val_q : v;
		next_cnt = extend ? cur_cnt_q + LEN_W'(1) : LEN_W'(1);

		push_data.has_a = close;
		push_data.len_a = cur_cnt_q;
		push_data.val_a = cur_val_q;
		push_data.len_b = next_cnt;
		push_data.val_b = next_val;
		push_data.last  = last_tile;
		push            = tile_fire && (close || last_tile);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_val_q <= '0;
			cur_cnt_q <= '0;
		end else if (tile_fire) begin
			if (last_tile) begin
				cur_val_q <= '0;
				cur_cnt_q <= '0;
			end else begin
				cur_val_q <= next_val;
				cur_cnt_q <= next_cnt;
			end
		end
	end

endmodule

>>> sv/mrle_queue.sv
// Small FIFO of run commands between the front end and the back end.
module mrle_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mrle_pkg::cmd_t push_data,
	input  logic           pop,
	output mrle_pkg::cmd_t head,
	output logic           empty,
	output logic           full
);
	import mrle_pkg::*;

	cmd_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + QUEUE_CW'(1);
				2'b01: count_q <= count_q - QUEUE_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));

endmodule

>>> sv/mrle_back.sv
// Back end: charges pairs against the room capacity and drives the result register.
module mrle_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [mrle_pkg::CAP_W-1:0]  capacity,
	input  mrle_pkg::cmd_t              head,
	input  logic                        empty,
	output logic                        pop,
	input  logic                        run_stall,
	output logic                        run_valid,
	output logic [mrle_pkg::LEN_W-1:0]  run_length,
	output logic [mrle_pkg::TILE_W-1:0] run_value,
	output logic                        room_done,
	output logic                        overflow
);
	import mrle_pkg::*;

	typedef enum logic {PH_PAIR, PH_FLUSH} phase_t;

	phase_t            phase_q;
	logic [CAP_W-1:0]  bytes_q;
	logic              ovf_q;
	logic              a_ovf_q;
	logic              out_valid_q;
	logic [LEN_W-1:0]  out_len_q;
	logic [TILE_W-1:0] out_val_q;
	logic              out_done_q;
	logic              out_ovf_q;

	logic out_ready;
	logic go;
	logic use_a;
	logic fits;
	logic emit;

	always_comb begin
		out_ready = !out_valid_q || !run_stall;
		go        = !empty && out_ready;
		use_a     = (phase_q == PH_PAIR) && head.has_a;
		fits      = ({1'b0, bytes_q} + (CAP_W + 1)'(2)) <= {1'b0, capacity};
		pop       = go && !(use_a && head.last);
		// A step gives a beat unless the room has already overflowed; the flush
		// step still closes a room that overflowed on an earlier command.
		emit      = use_a ? !ovf_q : (!ovf_q || !a_ovf_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PAIR;
			bytes_q     <= '0;
			ovf_q       <= 1'b0;
			a_ovf_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_len_q   <= '0;
			out_val_q   <= '0;
			out_done_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= go && emit;
			end
			if (go) begin
				if (use_a) begin
					if (!ovf_q) begin
						if (fits) begin
							out_len_q  <= head.len_a;
							out_val_q  <= head.val_a;
							out_done_q <= 1'b0;
							out_ovf_q  <= 1'b0;
							bytes_q    <= bytes_q + CAP_W'(2);
						end else begin
							// The room's last result when nothing can follow it.
							out_len_q  <= '0;
							out_val_q  <= '0;
							out_done_q <= head.last;
							out_ovf_q  <= 1'b1;
							ovf_q      <= 1'b1;
							a_ovf_q    <= head.last;
						end
					end
					if (head.last) begin
						phase_q <= PH_FLUSH;
					end
				end else begin
					if (!ovf_q) begin
						out_done_q  <= 1'b1;
						if (fits) begin
							out_len_q <= head.len_b;
							out_val_q <= head.val_b;
							out_ovf_q <= 1'b0;
						end else begin
							out_len_q <= '0;
							out_val_q <= '0;
							out_ovf_q <= 1'b1;
						end
					end else if (!a_ovf_q) begin
						// Overflowed earlier in the room: close it on an overflow beat.
						out_done_q  <= 1'b1;
						out_len_q   <= '0;
						out_val_q   <= '0;
						out_ovf_q   <= 1'b1;
					end
					bytes_q <= '0;
					ovf_q   <= 1'b0;
					a_ovf_q <= 1'b0;
					phase_q <= PH_PAIR;
				end
			end
		end
	end

	assign run_valid  = out_valid_q;
	assign run_length = out_len_q;
	assign run_value  = out_val_q;
	assign room_done  = out_done_q;
	assign overflow   = out_ovf_q;

endmodule

>>> sv/mrle_checker.sv
// Port-level checker for the masked run-length encoder, with its bind.
`include "masked_run_length_encoder_assert.svh"

module mrle_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         tile_valid,
	input logic                         tile_stall,
	input logic [mrle_pkg::TILE_W-1:0]  tile_value,
	input logic                         last_tile,
	input logic                         run_valid,
	input logic                         run_stall,
	input logic [mrle_pkg::LEN_W-1:0]   run_length,
	input logic [mrle_pkg::TILE_W-1:0]  run_value,
	input logic                         room_done,
	input logic                         overflow,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [mrle_pkg::PADDR_W-1:0] paddr,
	input logic [mrle_pkg::APB_DW-1:0]  pwdata,
	input logic [mrle_pkg::APB_DW-1:0]  prdata,
	input logic                         pready
);
	import mrle_pkg::*;

	`MRLE_ASSERT_NEXT(a_tile_hold, clk, arst_n, tile_valid && tile_stall, tile_valid && $stable(tile_value) && $stable(last_tile))
	`MRLE_ASSERT_NEXT(a_run_hold, clk, arst_n, run_valid && run_stall, run_valid && $stable(run_length) && $stable(run_value) && $stable(room_done) && $stable(overflow))
	`MRLE_ASSERT_IMPL(a_ovf_empty, clk, arst_n, run_valid && overflow, (run_length == '0) && (run_value == '0))
	`MRLE_ASSERT_IMPL(a_pair_len, clk, arst_n, run_valid && !overflow, run_length != '0)
	`MRLE_ASSERT_NEXT(a_cap_write, clk, arst_n, psel && penable && pwrite && pready && (paddr[PADDR_W-1:2] == REG_CAPACITY), (paddr[PADDR_W-1:2] != REG_CAPACITY) || (prdata[CAP_W-1:0] == $past(pwdata[CAP_W-1:0])))

endmodule

bind masked_run_length_encoder mrle_checker u_mrle_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for the masked run-length encoder, with a run-pair scoreboard.
module testbench;

	// A cycle count with nothing accepted on either channel and no register access
	// that ends the run as a hang. It covers the long receiver hold-off with margin.
	localparam int STALL_LIMIT = 4000;
	// Least number of tiles per random phase, not counting the long rooms of the run-limit phase.
	localparam int PHASE_ITEMS = 75;
	// Length of the receiver hold-off that fills the block and stalls its tile input.
	localparam int LONG_HOLD = 300;
	// Cycles allowed for the pipeline to settle before a register write and at the end.
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 20;
	localparam int NUM_PHASES = 8;

	// One expected beat of the run result channel.
	typedef struct {
		bit [7:0] len;
		bit [7:0] val;
		bit       done;
		bit       ovf;
	} run_beat_t;

	// Predicts the run pairs of each room and checks the beats the block sends.
	class RunScoreboard;
		int        capacity;
		bit [7:0]  open_value;
		int        open_count;
		int        bytes_used;
		bit        overflowed;
		run_beat_t expected_runs[$];
		int        errors;

		function new();
			capacity = mrle_pkg::CAP_RESET;
			errors = 0;
			clear_room();
		endfunction

		// Entity codes are written to the encoded room as empty tiles.
		static function bit is_sprite_code(bit [7:0] code);
			case (code)
				8'd8, 8'd11, 8'd12, 8'd18, 8'd20, 8'd22, 8'd23, 8'd26, 8'd28,
				8'd64, 8'd86, 8'd96, 8'd118: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		function void clear_room();
			open_value = '0;
			open_count = 0;
			bytes_used = 0;
			overflowed = 1'b0;
		endfunction

		function void push_beat(bit [7:0] len, bit [7:0] val, bit ovf);
			run_beat_t b;
			b.len = len;
			b.val = val;
			b.done = 1'b0;
			b.ovf = ovf;
			expected_runs.push_back(b);
		endfunction

		// A closed run costs two bytes; the first one that does not fit becomes a
		// single overflow beat and every later pair of the room is dropped.
		function void close_run(int len, bit [7:0] val);
			if (overflowed)
				return;
			if (bytes_used + 2 > capacity) begin
				overflowed = 1'b1;
				push_beat(8'd0, 8'd0, 1'b1);
			end else begin
				bytes_used += 2;
				push_beat(len[7:0], val, 1'b0);
			end
		endfunction

		function void note_tile(bit [7:0] tile, bit last);
			bit [7:0]  v;
			bit        was_overflowed;
			int        queued_before;
			run_beat_t b;
			v = is_sprite_code(tile) ? 8'd0 : tile;
			was_overflowed = overflowed;
			queued_before = expected_runs.size();
			if (open_count == 0) begin
				open_value = v;
				open_count = 1;
			end else if (v == open_value && open_count < int'(mrle_pkg::MAX_RUN)) begin
				open_count++;
			end else begin
				close_run(open_count, open_value);
				open_value = v;
				open_count = 1;
			end
			if (last) begin
				close_run(open_count, open_value);
				// A room that overflowed earlier still ends on a visible beat.
				if (expected_runs.size() == queued_before && was_overflowed)
					push_beat(8'd0, 8'd0, 1'b1);
				if (expected_runs.size() > queued_before) begin
					b = expected_runs.pop_back();
					b.done = 1'b1;
					expected_runs.push_back(b);
				end
				clear_room();
			end
		endfunction

		function void check_run(logic [7:0] len, logic [7:0] val, logic done, logic ovf);
			run_beat_t b;
			if (expected_runs.size() == 0) begin
				$error("run beat with none expected: length %0d value %0d done %b overflow %b",
					len, val, done, ovf);
				errors++;
				return;
			end
			b = expected_runs.pop_front();
			if (len !== b.len) begin
				$error("run_length: expected %0d, got %0d", b.len, len);
				errors++;
			end
			if (val !== b.val) begin
				$error("run_value: expected %0d, got %0d", b.val, val);
				errors++;
			end
			if (done !== b.done) begin
				$error("room_done: expected %b, got %b", b.done, done);
				errors++;
			end
			if (ovf !== b.ovf) begin
				$error("overflow: expected %b, got %b", b.ovf, ovf);
				errors++;
			end
		endfunction
	endclass

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               tile_valid;
	logic                               tile_stall;
	logic [mrle_pkg::TILE_W-1:0]        tile_value;
	logic                               last_tile;
	logic                               run_valid;
	logic                               run_stall = 1'b0;
	logic [mrle_pkg::LEN_W-1:0]         run_length;
	logic [mrle_pkg::TILE_W-1:0]        run_value;
	logic                               room_done;
	logic                               overflow;
	logic                               psel;
	logic                               penable;
	logic                               pwrite;
	logic [mrle_pkg::PADDR_W-1:0]       paddr;
	logic [mrle_pkg::APB_DW-1:0]        pwdata;
	logic [mrle_pkg::APB_DW-1:0]        prdata;
	logic                               pready;

	RunScoreboard sb = new();

	// Percent of cycles in which the sender idles and the receiver stalls.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// Remaining cycles of a forced receiver hold-off.
	int hold_left = 0;
	int items_sent = 0;
	bit [7:0] room_tiles[$];

	masked_run_length_encoder i_dut (.*);

	always #5 clk = ~clk;

	// The receiver stalls at random, or without a break while a hold-off runs.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			run_stall <= 1'b1;
		end else begin
			run_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Every beat accepted on the result channel is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && run_valid === 1'b1 && run_stall === 1'b0)
			sb.check_run(run_length, run_value, room_done, overflow);
	end

	// Watchdog: a long stretch with no progress at all means the block has hung.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((tile_valid === 1'b1 && tile_stall === 1'b0) ||
					(run_valid === 1'b1 && run_stall === 1'b0) || psel === 1'b1)
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Offers one tile beat, after random idle cycles, and holds it until it is taken.
	task automatic send_tile(bit [7:0] t, bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			tile_valid <= 1'b0;
			@(posedge clk);
		end
		tile_valid <= 1'b1;
		tile_value <= t;
		last_tile <= last;
		do @(posedge clk); while (tile_stall !== 1'b0);
		sb.note_tile(t, last);
		items_sent++;
	endtask

	// Sends the tiles gathered in room_tiles as one room.
	task automatic send_room();
		for (int i = 0; i < room_tiles.size(); i++)
			send_tile(room_tiles[i], i == room_tiles.size() - 1);
		room_tiles.delete();
	endtask

	// Tile picker biased toward repeats, entity codes and zeros, so that runs form
	// and masked entities merge with real empty tiles.
	function automatic bit [7:0] pick_tile(bit [7:0] prev);
		int r;
		bit [7:0] t;
		r = $urandom_range(99);
		if (r < 35)
			return prev;
		if (r < 50) begin
			do t = $urandom_range(127); while (!RunScoreboard::is_sprite_code(t));
			return t;
		end
		if (r < 60)
			return 8'd0;
		if (r < 65)
			return $urandom_range(1) ? 8'hFF : 8'h01;
		t = $urandom;
		return t;
	endfunction

	task automatic send_random_room();
		int n;
		bit [7:0] t;
		n = ($urandom_range(9) == 0) ? $urandom_range(21, 60) : $urandom_range(1, 20);
		t = $urandom;
		for (int i = 0; i < n; i++) begin
			t = pick_tile(t);
			send_tile(t, i == n - 1);
		end
	endtask

	task automatic wait_drained();
		while (sb.expected_runs.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(logic [mrle_pkg::PADDR_W-1:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_check_read(logic [mrle_pkg::PADDR_W-1:0] addr, logic [31:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== want) begin
			$error("output_capacity_bytes readback: expected %0d, got %0d", want, prdata);
			sb.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		logic [mrle_pkg::PADDR_W-1:0] cap_addr;
		int cap;
		int phase_start;
		bit paused;
		bit [7:0] v;
		int n;

		cap_addr = {mrle_pkg::REG_CAPACITY, 2'b00};
		arst_n = 1'b0;
		tile_valid = 1'b0;
		tile_value = '0;
		last_tile = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The capacity register must come out of reset at its full value.
		apb_check_read(cap_addr, 32'(mrle_pkg::CAP_RESET));

		// Directed rooms. A single-tile room flushes its only run on the last tile.
		room_tiles.push_back(8'd0);
		send_room();
		// Extreme codes, and two entity codes that merge with a real zero tile.
		room_tiles = '{8'd255, 8'd255, 8'd18, 8'd0, 8'd22, 8'd7};
		send_room();
		// A room whose last tile extends the open run instead of closing it.
		room_tiles = '{8'd1, 8'd1, 8'd1, 8'd1};
		send_room();
		// Every entity code in turn: they all mask to one run of zeros.
		for (int c = 0; c < 128; c++)
			if (RunScoreboard::is_sprite_code(c[7:0]))
				room_tiles.push_back(c[7:0]);
		send_room();

		// Random phases. Each one sets a new capacity with the block idle, then
		// streams rooms under its own idle pattern. Capacities of zero and one make
		// the first pair of every room overflow; small ones overflow mid-room, so
		// rooms also end after an earlier overflow.
		for (int p = 0; p < NUM_PHASES; p++) begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
			tile_valid <= 1'b0;
			wait_drained();
			repeat (SETTLE_CYCLES) @(posedge clk);
			case (p)
				0, 6: cap = 512;
				1: cap = 0;
				2: cap = 1;
				3: cap = 2;
				4: cap = 6;
				5: cap = $urandom_range(3, 40);
				default: cap = $urandom_range(0, 512);
			endcase
			apb_write(cap_addr, cap);
			sb.capacity = cap;
			apb_check_read(cap_addr, cap);

			// Idle patterns rotate: none, sender only, receiver only, both.
			case (p % 4)
				1: send_idle_pct = 76;
				2: recv_stall_pct = 76;
				3: begin
					send_idle_pct = 29;
					recv_stall_pct = 29;
				end
				default: ;
			endcase

			// Hold the receiver off while the sender keeps streaming, so the command
			// queue fills and the block must stall its tile input.
			if (p == 2)
				hold_left = LONG_HOLD;

			// At full capacity: a run that reaches the run limit and, if longer, reopens,
			// then a room of alternating tiles that runs out of bytes after 256 pairs.
			if (p == 6) begin
				v = $urandom;
				n = $urandom_range(255, 300);
				for (int i = 0; i < n; i++)
					send_tile(v, i == n - 1);
				v = $urandom_range(128, 255);
				n = $urandom_range(258, 270);
				for (int i = 0; i < n; i++)
					send_tile(i[0] ? v : v ^ 8'h01, i == n - 1);
			end

			phase_start = items_sent;
			paused = 1'b0;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				// Once, the sender stops mid-phase until every result has come out.
				if (p == 1 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
					tile_valid <= 1'b0;
					wait_drained();
					paused = 1'b1;
				end
				send_random_room();
			end
		end

		tile_valid <= 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_runs.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
